[src/csc_pkg.sv]
// Shared types, constants and arithmetic helpers of the colour space converter.
`timescale 1ns / 1ps
package csc_pkg;

    typedef enum logic [2:0] {
        SP_RGB   = 3'd0,
        SP_HSV   = 3'd1,
        SP_HSL   = 3'd2,
        SP_601   = 3'd3,
        SP_709   = 3'd4,
        SP_YCOCG = 3'd5,
        SP_CMY   = 3'd6
    } t_space;

    localparam logic REG_SRC = 1'b0;
    localparam logic REG_TGT = 1'b1;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_pix;

    // Rounded divide by 390150 through a reciprocal, dividends below 2^27.
    localparam int unsigned HSL_DEN    = 390150;
    localparam int unsigned DIV_RECIP  = 344;
    localparam int unsigned DIV_SHIFT  = 27;
    localparam int unsigned HSV_OFS    = 65025;
    localparam int unsigned HSL_OFS    = 195075;

    // Widths of the hue and saturation divider.
    localparam int unsigned DRW = 20;
    localparam int unsigned DDW = 12;

    // Matrix coefficients in units of 1e-8.
    localparam longint C_0299   = 29900000;
    localparam longint C_0587   = 58700000;
    localparam longint C_0114   = 11400000;
    localparam longint C_168736 = 16873600;
    localparam longint C_331264 = 33126400;
    localparam longint C_0500   = 50000000;
    localparam longint C_418688 = 41868800;
    localparam longint C_081312 = 8131200;
    localparam longint C_02126  = 21260000;
    localparam longint C_07152  = 71520000;
    localparam longint C_00722  = 7220000;
    localparam longint C_114572 = 11457211;
    localparam longint C_385428 = 38542789;
    localparam longint C_454153 = 45415291;
    localparam longint C_045847 = 4584709;
    localparam longint C_1402   = 140200000;
    localparam longint C_344136 = 34413600;
    localparam longint C_714136 = 71413600;
    localparam longint C_1772   = 177200000;
    localparam longint C_15748  = 157480000;
    localparam longint C_187324 = 18732427;
    localparam longint C_468124 = 46812427;
    localparam longint C_18556  = 185560000;

    function automatic longint fixc(input int unsigned fb, input longint c8);
        fixc = ((c8 << fb) + 64'sd50000000) / 64'sd100000000;
    endfunction

    function automatic logic [7:0] fix_u8(input logic signed [47:0] acc,
                                          input int unsigned fb);
        logic signed [47:0] v;
        v = (acc + (48'sd1 <<< (fb - 1))) >>> fb;
        if (acc <= 48'sd0) begin
            fix_u8 = 8'd0;
        end else if (v > 48'sd255) begin
            fix_u8 = 8'd255;
        end else begin
            fix_u8 = v[7:0];
        end
    endfunction

    function automatic logic [DRW:0] div_step(input logic [DRW-1:0] rem,
                                              input logic [DDW-1:0] dv,
                                              input int unsigned sh);
        logic [DRW-1:0] dsh;
        dsh = DRW'(dv) << sh;
        if (rem >= dsh) begin
            div_step = {1'b1, rem - dsh};
        end else begin
            div_step = {1'b0, rem};
        end
    endfunction

endpackage

[src/csc_if.sv]
// Handshake interfaces of the colour space converter: pixel in, pixel out, register writes.
`timescale 1ns / 1ps
interface csc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_a_in;
    logic [7:0] chan_b_in;
    logic [7:0] chan_c_in;
    modport source (output valid, output chan_a_in, output chan_b_in, output chan_c_in,
                    input ready);
    modport sink (input valid, input chan_a_in, input chan_b_in, input chan_c_in,
                  output ready);
endinterface

interface csc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_a_out;
    logic [7:0] chan_b_out;
    logic [7:0] chan_c_out;
    modport source (output valid, output chan_a_out, output chan_b_out, output chan_c_out,
                    input ready);
    modport sink (input valid, input chan_a_out, input chan_b_out, input chan_c_out,
                  output ready);
endinterface

interface csc_cfg_if;
    logic       valid;
    logic       ready;
    logic       reg_index;
    logic [2:0] wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[src/csc_to_rgb.sv]
// Five-stage pipeline that takes a pixel from the source space to RGB.
`timescale 1ns / 1ps
module csc_to_rgb
    import csc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic [4:0] i_en,
    input  logic [2:0] i_src,
    input  t_pix       i_pix,
    output t_pix       o_pix
);

    localparam int unsigned CW = FRAC_BITS + 3;
    localparam int unsigned AW = FRAC_BITS + 12;

    localparam logic signed [CW-1:0] K6_RCR = CW'(fixc(FRAC_BITS, C_1402));
    localparam logic signed [CW-1:0] K6_GCB = CW'(-fixc(FRAC_BITS, C_344136));
    localparam logic signed [CW-1:0] K6_GCR = CW'(-fixc(FRAC_BITS, C_714136));
    localparam logic signed [CW-1:0] K6_BCB = CW'(fixc(FRAC_BITS, C_1772));
    localparam logic signed [CW-1:0] K7_RCR = CW'(fixc(FRAC_BITS, C_15748));
    localparam logic signed [CW-1:0] K7_GCB = CW'(-fixc(FRAC_BITS, C_187324));
    localparam logic signed [CW-1:0] K7_GCR = CW'(-fixc(FRAC_BITS, C_468124));
    localparam logic signed [CW-1:0] K7_BCB = CW'(fixc(FRAC_BITS, C_18556));

    function automatic logic [9:0] hsl_fac(input logic [9:0] t);
        logic [10:0] t2;
        t2 = {t, 1'b0};
        if (t2 < 11'd255) begin
            hsl_fac = 10'(t * 10'd6);
        end else if (t2 < 11'd765) begin
            hsl_fac = 10'd765;
        end else if (t < 10'd510) begin
            hsl_fac = 10'((10'd510 - t) * 10'd6);
        end else begin
            hsl_fac = 10'd0;
        end
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [10:0] v);
        if (v < 11'sd0) begin
            clamp8 = 8'd0;
        end else if (v > 11'sd255) begin
            clamp8 = 8'd255;
        end else begin
            clamp8 = v[7:0];
        end
    endfunction

    // Stage 1
    logic [10:0] w_h6;
    logic [2:0]  w_k;
    logic [7:0]  w_f;
    logic [9:0]  w_h3;
    logic [9:0]  w_t [3];
    logic [15:0] w_ls;
    logic [17:0] w_q;
    logic signed [8:0]  w_cb, w_cr;
    logic signed [10:0] w_yr, w_yg, w_yb;
    logic signed [CW-1:0] w_kr, w_kgb, w_kgr, w_kbb;
    t_pix        w_dir1;

    logic [15:0] r1_vs;
    logic [7:0]  r1_v, r1_w, r1_y;
    logic [2:0]  r1_k;
    logic [15:0] r1_q, r1_pv;
    logic [9:0]  r1_fac [3];
    logic signed [AW-1:0] r1_p [4];
    t_pix        r1_dir;

    always_comb begin
        w_h6 = 11'(i_pix.a) * 11'd6;
        if (w_h6 >= 11'd1530) begin
            w_k = 3'd0;
        end else if (w_h6 >= 11'd1275) begin
            w_k = 3'd5;
        end else if (w_h6 >= 11'd1020) begin
            w_k = 3'd4;
        end else if (w_h6 >= 11'd765) begin
            w_k = 3'd3;
        end else if (w_h6 >= 11'd510) begin
            w_k = 3'd2;
        end else if (w_h6 >= 11'd255) begin
            w_k = 3'd1;
        end else begin
            w_k = 3'd0;
        end
        if (w_h6 >= 11'd1530) begin
            w_f = 8'd0;
        end else begin
            w_f = 8'(w_h6 - 11'(w_k) * 11'd255);
        end

        w_h3 = 10'(i_pix.a) * 10'd3;
        w_t[0] = w_h3 + 10'd255;
        if (w_t[0] > 10'd765) begin
            w_t[0] = w_t[0] - 10'd765;
        end
        w_t[1] = w_h3;
        if (w_h3 < 10'd255) begin
            w_t[2] = w_h3 + 10'd510;
        end else begin
            w_t[2] = w_h3 - 10'd255;
        end
        w_ls = 16'(i_pix.c) * 16'(i_pix.b);
        if (i_pix.c < 8'd128) begin
            w_q = 18'(i_pix.c) * 18'd255 + 18'(w_ls);
        end else begin
            w_q = (18'(i_pix.c) + 18'(i_pix.b)) * 18'd255 - 18'(w_ls);
        end

        w_cb = $signed({1'b0, i_pix.b}) - 9'sd128;
        w_cr = $signed({1'b0, i_pix.c}) - 9'sd128;
        if (i_src == SP_709) begin
            w_kr = K7_RCR;
            w_kgb = K7_GCB;
            w_kgr = K7_GCR;
            w_kbb = K7_BCB;
        end else begin
            w_kr = K6_RCR;
            w_kgb = K6_GCB;
            w_kgr = K6_GCR;
            w_kbb = K6_BCB;
        end

        w_yr = $signed({3'b0, i_pix.a}) + $signed({3'b0, i_pix.b}) - $signed({3'b0, i_pix.c});
        w_yg = $signed({3'b0, i_pix.a}) + $signed({3'b0, i_pix.c}) - 11'sd128;
        w_yb = $signed({3'b0, i_pix.a}) - $signed({3'b0, i_pix.b})
             - $signed({3'b0, i_pix.c}) + 11'sd256;
        case (i_src)
            SP_YCOCG: w_dir1 = '{clamp8(w_yr), clamp8(w_yg), clamp8(w_yb)};
            SP_CMY:   w_dir1 = ~i_pix;
            default:  w_dir1 = i_pix;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_vs <= w_ls;
            r1_v <= i_pix.c;
            r1_w <= w_k[0] ? 8'd255 - w_f : w_f;
            r1_k <= w_k;
            r1_y <= i_pix.a;
            r1_q <= w_q[15:0];
            r1_pv <= 16'(18'(i_pix.c) * 18'd510 - w_q);
            for (int i = 0; i < 3; i++) begin
                r1_fac[i] <= hsl_fac(w_t[i]);
            end
            r1_p[0] <= AW'(w_kr) * AW'(w_cr);
            r1_p[1] <= AW'(w_kgb) * AW'(w_cb);
            r1_p[2] <= AW'(w_kgr) * AW'(w_cr);
            r1_p[3] <= AW'(w_kbb) * AW'(w_cb);
            r1_dir <= w_dir1;
        end
    end

    // Stage 2
    logic [23:0] w_hi, w_lo, w_mid;
    logic [26:0] w_n [3];
    logic [26:0] w_x [3];
    logic signed [AW-1:0] w_yb2;
    t_pix        w_dir2;

    logic [26:0] r2_x [3];
    logic [2:0]  r2_k;
    t_pix        r2_dir;

    always_comb begin
        w_hi = 24'(r1_v) * 24'd65025;
        w_lo = w_hi - 24'(r1_vs) * 24'd255;
        w_mid = w_lo + 24'(r1_vs) * 24'(r1_w);
        for (int i = 0; i < 3; i++) begin
            w_n[i] = 27'(r1_pv) * 27'd765 + 27'(r1_q - r1_pv) * 27'(r1_fac[i]);
        end
        if (i_src == SP_HSV) begin
            w_x[0] = 27'd3 * ((27'(w_hi) << 1) + 27'(HSV_OFS));
            w_x[1] = 27'd3 * ((27'(w_mid) << 1) + 27'(HSV_OFS));
            w_x[2] = 27'd3 * ((27'(w_lo) << 1) + 27'(HSV_OFS));
        end else begin
            for (int i = 0; i < 3; i++) begin
                w_x[i] = (w_n[i] << 1) + 27'(HSL_OFS);
            end
        end
        w_yb2 = AW'($signed({1'b0, r1_y})) <<< FRAC_BITS;
        case (i_src)
            SP_601, SP_709: begin
                w_dir2.a = fix_u8(48'(w_yb2 + r1_p[0]), FRAC_BITS);
                w_dir2.b = fix_u8(48'(w_yb2 + r1_p[1] + r1_p[2]), FRAC_BITS);
                w_dir2.c = fix_u8(48'(w_yb2 + r1_p[3]), FRAC_BITS);
            end
            default: w_dir2 = r1_dir;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_x <= w_x;
            r2_k <= r1_k;
            r2_dir <= w_dir2;
        end
    end

    // Stage 3
    logic [35:0] r3_prod [3];
    logic [26:0] r3_x [3];
    logic [2:0]  r3_k;
    t_pix        r3_dir;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_prod[i] <= 36'(r2_x[i]) * 36'(DIV_RECIP);
            end
            r3_x <= r2_x;
            r3_k <= r2_k;
            r3_dir <= r2_dir;
        end
    end

    // Stage 4
    logic [8:0]  w_q0 [3];
    logic [8:0]  r4_q0 [3];
    logic [19:0] r4_r [3];
    logic [2:0]  r4_k;
    t_pix        r4_dir;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q0[i] = 9'(r3_prod[i] >> DIV_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r4_q0[i] <= w_q0[i];
                r4_r[i] <= 20'(r3_x[i] - 27'(w_q0[i]) * 27'(HSL_DEN));
            end
            r4_k <= r3_k;
            r4_dir <= r3_dir;
        end
    end

    // Stage 5
    logic [9:0] w_qf [3];
    logic [7:0] w_qs [3];
    t_pix       w_rgb;
    t_pix       r5_rgb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qf[i] = 10'(r4_q0[i]) + 10'(r4_r[i] >= 20'(HSL_DEN));
            w_qs[i] = (w_qf[i] > 10'd255) ? 8'd255 : w_qf[i][7:0];
        end
        case (i_src)
            SP_HSV: begin
                case (r4_k)
                    3'd0:    w_rgb = '{w_qs[0], w_qs[1], w_qs[2]};
                    3'd1:    w_rgb = '{w_qs[1], w_qs[0], w_qs[2]};
                    3'd2:    w_rgb = '{w_qs[2], w_qs[0], w_qs[1]};
                    3'd3:    w_rgb = '{w_qs[2], w_qs[1], w_qs[0]};
                    3'd4:    w_rgb = '{w_qs[1], w_qs[2], w_qs[0]};
                    default: w_rgb = '{w_qs[0], w_qs[2], w_qs[1]};
                endcase
            end
            SP_HSL:  w_rgb = '{w_qs[0], w_qs[1], w_qs[2]};
            default: w_rgb = r4_dir;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_rgb <= w_rgb;
        end
    end

    assign o_pix = r5_rgb;

endmodule

[src/color_space_converter_top.sv]
// Top level of the colour space converter: handshake, registers and the RGB to target pipeline.
`timescale 1ns / 1ps
// Converts one 8-bit three-channel pixel per clock while the output is not stalled, from the
// source space (register 0) to the target space (register 1), codes 0 RGB, 1 HSV, 2 HSL,
// 3 YCbCr 601, 4 YCbCr 709, 5 YCoCg, 6 CMY; equal codes pass the pixel through unchanged.
// Five stages bring each word to RGB, where the HSV and HSL inverses share a reciprocal
// divider, and six stages take it to the target, four of them a two-bit-per-stage divider
// for hue and saturation. Stalls at the output hold only the stages that are full.
// Registers should be written only while no word is in flight.
module color_space_converter_top
    import csc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    csc_in_if.sink    i_pix,
    csc_out_if.source o_pix,
    csc_cfg_if.sink   i_cfg
);

    localparam int unsigned NST = 11;
    localparam int unsigned CW  = FRAC_BITS + 3;
    localparam int unsigned AW  = FRAC_BITS + 12;

    localparam logic signed [CW-1:0] KF6 [9] = '{
        CW'(fixc(FRAC_BITS, C_0299)), CW'(fixc(FRAC_BITS, C_0587)),
        CW'(fixc(FRAC_BITS, C_0114)),
        CW'(-fixc(FRAC_BITS, C_168736)), CW'(-fixc(FRAC_BITS, C_331264)),
        CW'(fixc(FRAC_BITS, C_0500)),
        CW'(fixc(FRAC_BITS, C_0500)), CW'(-fixc(FRAC_BITS, C_418688)),
        CW'(-fixc(FRAC_BITS, C_081312))
    };
    localparam logic signed [CW-1:0] KF7 [9] = '{
        CW'(fixc(FRAC_BITS, C_02126)), CW'(fixc(FRAC_BITS, C_07152)),
        CW'(fixc(FRAC_BITS, C_00722)),
        CW'(-fixc(FRAC_BITS, C_114572)), CW'(-fixc(FRAC_BITS, C_385428)),
        CW'(fixc(FRAC_BITS, C_0500)),
        CW'(fixc(FRAC_BITS, C_0500)), CW'(-fixc(FRAC_BITS, C_454153)),
        CW'(-fixc(FRAC_BITS, C_045847))
    };
    localparam logic signed [AW-1:0] MOFS = AW'(longint'(128) << FRAC_BITS);

    logic [2:0] r_src, r_tgt;
    logic [2:0] w_src, w_tgt;
    logic       w_same;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= SP_RGB;
            r_tgt <= SP_RGB;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == REG_SRC) begin
                r_src <= i_cfg.wdata;
            end else begin
                r_tgt <= i_cfg.wdata;
            end
        end
    end

    assign w_same = (r_src == r_tgt);
    assign w_src  = w_same ? SP_RGB : r_src;
    assign w_tgt  = w_same ? SP_RGB : r_tgt;

    logic [NST-1:0] r_vld, w_adv;

    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || o_pix.ready;
        for (int i = NST - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign i_pix.ready = w_adv[0];

    t_pix w_in, w_rgb;

    assign w_in = '{i_pix.chan_a_in, i_pix.chan_b_in, i_pix.chan_c_in};

    csc_to_rgb #(
        .FRAC_BITS(FRAC_BITS)
    ) u_to_rgb (
        .i_clk (i_clk),
        .i_en  (w_adv[4:0]),
        .i_src (w_src),
        .i_pix (w_in),
        .o_pix (w_rgb)
    );

    // Stage 6
    logic [10:0] w_cy0, w_cy1, w_cy2;
    t_pix        w_dir6;
    logic [7:0]  r6_mx, r6_mn;
    logic        r6_rmax, r6_gmax;
    t_pix        r6_pix, r6_dir;
    logic signed [AW-1:0] r6_fp [9];

    always_comb begin
        w_cy0 = (11'(w_rgb.a) + (11'(w_rgb.b) << 1) + 11'(w_rgb.c)) >> 2;
        w_cy1 = (11'(w_rgb.a) + 11'd256 - 11'(w_rgb.c)) >> 1;
        w_cy2 = ((11'(w_rgb.b) << 1) + 11'd512 - 11'(w_rgb.a) - 11'(w_rgb.c)) >> 2;
        case (w_tgt)
            SP_YCOCG: w_dir6 = '{w_cy0[7:0], w_cy1[7:0], w_cy2[7:0]};
            SP_CMY:   w_dir6 = ~w_rgb;
            default:  w_dir6 = w_rgb;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r6_rmax <= (w_rgb.a >= w_rgb.b) && (w_rgb.a >= w_rgb.c);
            r6_gmax <= (w_rgb.b >= w_rgb.c);
            r6_mx <= (w_rgb.a >= w_rgb.b)
                   ? ((w_rgb.a >= w_rgb.c) ? w_rgb.a : w_rgb.c)
                   : ((w_rgb.b >= w_rgb.c) ? w_rgb.b : w_rgb.c);
            r6_mn <= (w_rgb.a <= w_rgb.b)
                   ? ((w_rgb.a <= w_rgb.c) ? w_rgb.a : w_rgb.c)
                   : ((w_rgb.b <= w_rgb.c) ? w_rgb.b : w_rgb.c);
            r6_pix <= w_rgb;
            r6_dir <= w_dir6;
            for (int i = 0; i < 9; i++) begin
                r6_fp[i] <= AW'((w_tgt == SP_709) ? KF7[i] : KF6[i])
                          * AW'($signed({1'b0, w_rgb[23 - 8*(i%3) -: 8]}));
            end
        end
    end

    // Stage 7 and the divider stages 8 to 10, held in one array
    logic [7:0]  w_d, w_den, w_val;
    logic [8:0]  w_sum;
    logic [10:0] w_d6;
    logic signed [12:0] w_num;
    logic        w_light;
    t_pix        w_dir7;

    logic [DRW-1:0] r_rem1 [4], r_rem2 [4];
    logic [DDW-1:0] r_dv1 [4], r_dv2 [4];
    logic [7:0]     r_q1 [4], r_q2 [4], r_val [4];
    logic           r_dz [4];
    t_pix           r_dir [4];

    logic [DRW:0] w_s1a [1:3], w_s1b [1:3], w_s2a [1:3], w_s2b [1:3];

    always_comb begin
        w_light = (w_tgt == SP_HSL);
        w_d = r6_mx - r6_mn;
        w_sum = 9'(r6_mx) + 9'(r6_mn);
        w_d6 = 11'(w_d) * 11'd6;
        if (r6_rmax) begin
            w_num = $signed({5'b0, r6_pix.b}) - $signed({5'b0, r6_pix.c});
            if (w_num < 13'sd0) begin
                w_num = w_num + $signed({2'b0, w_d6});
            end
        end else if (r6_gmax) begin
            w_num = $signed({4'b0, w_d, 1'b0}) + $signed({5'b0, r6_pix.c})
                  - $signed({5'b0, r6_pix.a});
        end else begin
            w_num = $signed({3'b0, w_d, 2'b0}) + $signed({5'b0, r6_pix.a})
                  - $signed({5'b0, r6_pix.b});
        end
        if (w_light) begin
            w_den = (w_sum > 9'd255) ? 8'(9'd510 - w_sum) : w_sum[7:0];
            w_val = 8'((10'(w_sum) + 10'd1) >> 1);
        end else begin
            w_den = r6_mx;
            w_val = r6_mx;
        end
        case (w_tgt)
            SP_601, SP_709: begin
                w_dir7.a = fix_u8(48'(r6_fp[0] + r6_fp[1] + r6_fp[2]), FRAC_BITS);
                w_dir7.b = fix_u8(48'(r6_fp[3] + r6_fp[4] + r6_fp[5] + MOFS), FRAC_BITS);
                w_dir7.c = fix_u8(48'(r6_fp[6] + r6_fp[7] + r6_fp[8] + MOFS), FRAC_BITS);
            end
            default: w_dir7 = r6_dir;
        endcase

        for (int j = 1; j < 4; j++) begin
            w_s1a[j] = div_step(r_rem1[j-1], r_dv1[j-1], 9 - 2*j);
            w_s1b[j] = div_step(w_s1a[j][DRW-1:0], r_dv1[j-1], 8 - 2*j);
            w_s2a[j] = div_step(r_rem2[j-1], r_dv2[j-1], 9 - 2*j);
            w_s2b[j] = div_step(w_s2a[j][DRW-1:0], r_dv2[j-1], 8 - 2*j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_rem1[0] <= 20'(w_num[10:0]) * 20'd510 + 20'(w_d6);
            r_dv1[0] <= 12'(w_d) * 12'd12;
            r_rem2[0] <= 20'(w_d) * 20'd510 + 20'(w_den);
            r_dv2[0] <= 12'(w_den) << 1;
            r_q1[0] <= 8'd0;
            r_q2[0] <= 8'd0;
            r_val[0] <= w_val;
            r_dz[0] <= (w_d == 8'd0);
            r_dir[0] <= w_dir7;
        end
        for (int j = 1; j < 4; j++) begin
            if (w_adv[6+j]) begin
                r_rem1[j] <= w_s1b[j][DRW-1:0];
                r_rem2[j] <= w_s2b[j][DRW-1:0];
                r_dv1[j] <= r_dv1[j-1];
                r_dv2[j] <= r_dv2[j-1];
                r_q1[j] <= {r_q1[j-1][5:0], w_s1a[j][DRW], w_s1b[j][DRW]};
                r_q2[j] <= {r_q2[j-1][5:0], w_s2a[j][DRW], w_s2b[j][DRW]};
                r_val[j] <= r_val[j-1];
                r_dz[j] <= r_dz[j-1];
                r_dir[j] <= r_dir[j-1];
            end
        end
    end

    // Stage 11: last divider bits and the output word
    logic [DRW:0] w_f1a, w_f1b, w_f2a, w_f2b;
    logic [7:0]   w_hq, w_sq;
    t_pix         w_res, r_out;

    always_comb begin
        w_f1a = div_step(r_rem1[3], r_dv1[3], 1);
        w_f1b = div_step(w_f1a[DRW-1:0], r_dv1[3], 0);
        w_f2a = div_step(r_rem2[3], r_dv2[3], 1);
        w_f2b = div_step(w_f2a[DRW-1:0], r_dv2[3], 0);
        w_hq = {r_q1[3][5:0], w_f1a[DRW], w_f1b[DRW]};
        w_sq = {r_q2[3][5:0], w_f2a[DRW], w_f2b[DRW]};
        if ((w_tgt == SP_HSV) || (w_tgt == SP_HSL)) begin
            w_res.a = r_dz[3] ? 8'd0 : w_hq;
            w_res.b = r_dz[3] ? 8'd0 : w_sq;
            w_res.c = r_val[3];
        end else begin
            w_res = r_dir[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) begin
            r_out <= w_res;
        end
    end

    assign o_pix.valid      = r_vld[NST-1];
    assign o_pix.chan_a_out = r_out.a;
    assign o_pix.chan_b_out = r_out.b;
    assign o_pix.chan_c_out = r_out.c;

`ifndef SYNTH
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] && !w_adv[5] |=> r_vld[5])
        else $error("stalled middle stage lost its word");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (&r_vld))
        else $error("input stalled while the pipeline has a bubble");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.ready && !r_vld[NST-2] |=> !o_pix.valid)
        else $error("output word repeated");
`endif

endmodule

[tb/sv/csc_tb_pkg.sv]
// Interfaces are in src; this file holds nothing but the testbench word type.
`timescale 1ns / 1ps
package csc_tb_pkg;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_word;

endpackage

[tb/sv/testbench.sv]
// Testbench of the colour space converter: random and directed pixels across all space pairs.
`timescale 1ns / 1ps
module testbench;
    import csc_pkg::*;
    import csc_tb_pkg::*;

    localparam int FB = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 11;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    csc_in_if  pix_in ();
    csc_out_if pix_out ();
    csc_cfg_if cfg ();

    color_space_converter_top #(.FRAC_BITS(FB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_in.sink),
        .o_pix  (pix_out.source),
        .i_cfg  (cfg.sink)
    );

    always #6 i_clk = ~i_clk;

    t_word pending_pixels[$];
    t_word expected_pixels[$];
    logic [2:0] src_space = SP_RGB;
    logic [2:0] tgt_space = SP_RGB;
    int fail_count = 0;
    int quiet_cycles = 0;
    int idle_pct = 17;
    bit cfg_pending = 1'b0;
    bit in_taken = 1'b0;
    logic cfg_index;
    logic [2:0] cfg_value;

    function automatic longint fx(input longint c8);
        return ((c8 <<< FB) + 64'sd50000000) / 64'sd100000000;
    endfunction

    function automatic int to_u8(input longint acc);
        longint v;
        if (acc <= 0) return 0;
        v = (acc + (64'sd1 <<< (FB - 1))) >>> FB;
        return v > 255 ? 255 : int'(v);
    endfunction

    function automatic int clamp8(input longint v);
        if (v < 0) return 0;
        return v > 255 ? 255 : int'(v);
    endfunction

    function automatic int rnd65025(input longint n);
        longint v;
        v = (2 * n + 65025) / 130050;
        return v > 255 ? 255 : int'(v);
    endfunction

    function automatic int hsl_channel(input longint pv, input longint q, input longint t);
        longint n, v;
        if (t < 0) t += 765;
        if (t > 765) t -= 765;
        if (2 * t < 255) n = pv * 765 + (q - pv) * 6 * t;
        else if (2 * t < 765) n = q * 765;
        else if (t < 510) n = pv * 765 + (q - pv) * 6 * (510 - t);
        else n = pv * 765;
        if (n < 0) n = 0;
        v = (2 * n + 195075) / 390150;
        return v > 255 ? 255 : int'(v);
    endfunction

    function automatic t_word convert_pixel(input t_word w, input logic [2:0] sp,
                                            input logic [2:0] tp);
        longint p[3];
        longint r, g, b, mx, mn, d, num, den, sum, h6, k, f, cn, hi, lo, md, q, pv, y, c1, c2;
        longint m[9];
        longint iv[6];
        t_word res;
        p[0] = w.a; p[1] = w.b; p[2] = w.c;
        if (sp != tp) begin
            case (sp)
                SP_HSV: begin
                    h6 = 6 * p[0]; k = h6 / 255; f = h6 % 255;
                    if (k >= 6) begin k = 0; f = 0; end
                    cn = p[2] * p[1] * 255; hi = p[2] * 65025; lo = hi - cn;
                    md = lo + p[2] * p[1] * ((k % 2 == 1) ? (255 - f) : f);
                    hi = rnd65025(hi); lo = rnd65025(lo); md = rnd65025(md);
                    case (k)
                        0: begin p[0] = hi; p[1] = md; p[2] = lo; end
                        1: begin p[0] = md; p[1] = hi; p[2] = lo; end
                        2: begin p[0] = lo; p[1] = hi; p[2] = md; end
                        3: begin p[0] = lo; p[1] = md; p[2] = hi; end
                        4: begin p[0] = md; p[1] = lo; p[2] = hi; end
                        default: begin p[0] = hi; p[1] = lo; p[2] = md; end
                    endcase
                end
                SP_HSL: begin
                    if (p[1] != 0) begin
                        if (2 * p[2] < 255) q = p[2] * (255 + p[1]);
                        else q = (p[2] + p[1]) * 255 - p[2] * p[1];
                        pv = 2 * p[2] * 255 - q;
                        r = hsl_channel(pv, q, 3 * p[0] + 255);
                        g = hsl_channel(pv, q, 3 * p[0]);
                        b = hsl_channel(pv, q, 3 * p[0] - 255);
                        p[0] = r; p[1] = g; p[2] = b;
                    end else begin
                        p[0] = p[2]; p[1] = p[2];
                    end
                end
                SP_601, SP_709: begin
                    if (sp == SP_601)
                        iv = '{0, fx(140200000), -fx(34413600), -fx(71413600), fx(177200000), 0};
                    else
                        iv = '{0, fx(157480000), -fx(18732427), -fx(46812427), fx(185560000), 0};
                    y = p[0] <<< FB; c1 = p[1] - 128; c2 = p[2] - 128;
                    for (int i = 0; i < 3; i++) p[i] = to_u8(y + iv[2*i] * c1 + iv[2*i+1] * c2);
                end
                SP_YCOCG: begin
                    y = p[0]; c1 = p[1] - 128; c2 = p[2] - 128;
                    p[0] = clamp8(y + c1 - c2); p[1] = clamp8(y + c2); p[2] = clamp8(y - c1 - c2);
                end
                SP_CMY: for (int i = 0; i < 3; i++) p[i] = 255 - p[i];
                default: ;
            endcase
            case (tp)
                SP_HSV, SP_HSL: begin
                    r = p[0]; g = p[1]; b = p[2];
                    mx = r; mn = r;
                    if (g > mx) mx = g;
                    if (b > mx) mx = b;
                    if (g < mn) mn = g;
                    if (b < mn) mn = b;
                    d = mx - mn; sum = mx + mn;
                    p[2] = (tp == SP_HSL) ? (sum + 1) / 2 : mx;
                    if (d == 0) begin
                        p[0] = 0; p[1] = 0;
                    end else begin
                        if (r == mx) begin
                            num = g - b;
                            if (num < 0) num += 6 * d;
                        end else if (g == mx) num = 2 * d + b - r;
                        else num = 4 * d + r - g;
                        p[0] = (510 * num + 6 * d) / (12 * d);
                        if (tp == SP_HSL) den = sum > 255 ? 510 - sum : sum;
                        else den = mx;
                        p[1] = (510 * d + den) / (2 * den);
                    end
                end
                SP_601, SP_709: begin
                    if (tp == SP_601)
                        m = '{fx(29900000), fx(58700000), fx(11400000),
                              -fx(16873600), -fx(33126400), fx(50000000),
                              fx(50000000), -fx(41868800), -fx(8131200)};
                    else
                        m = '{fx(21260000), fx(71520000), fx(7220000),
                              -fx(11457211), -fx(38542789), fx(50000000),
                              fx(50000000), -fx(45415291), -fx(4584709)};
                    r = p[0]; g = p[1]; b = p[2];
                    for (int i = 0; i < 3; i++)
                        p[i] = to_u8(m[3*i] * r + m[3*i+1] * g + m[3*i+2] * b
                                     + ((i > 0) ? (64'sd128 <<< FB) : 64'sd0));
                end
                SP_YCOCG: begin
                    r = p[0]; g = p[1]; b = p[2];
                    p[0] = clamp8((r + 2 * g + b) / 4);
                    p[1] = clamp8((r - b + 256) / 2);
                    p[2] = clamp8((2 * g - r - b + 512) / 4);
                end
                SP_CMY: for (int i = 0; i < 3; i++) p[i] = 255 - p[i];
                default: ;
            endcase
        end
        res.a = p[0][7:0]; res.b = p[1][7:0]; res.c = p[2][7:0];
        return res;
    endfunction

    initial begin
        pix_in.valid = 1'b0;
        pix_in.chan_a_in = '0;
        pix_in.chan_b_in = '0;
        pix_in.chan_c_in = '0;
        pix_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.reg_index = REG_SRC;
        cfg.wdata = '0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!pix_in.valid || in_taken) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    pix_in.valid <= 1'b1;
                    pix_in.chan_a_in <= pending_pixels[0].a;
                    pix_in.chan_b_in <= pending_pixels[0].b;
                    pix_in.chan_c_in <= pending_pixels[0].c;
                    void'(pending_pixels.pop_front());
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
            pix_out.ready <= ($urandom_range(99) >= idle_pct);
            if (cfg_pending && !(cfg.valid && cfg.ready)) begin
                cfg.valid <= 1'b1;
                cfg.reg_index <= cfg_index;
                cfg.wdata <= cfg_value;
            end else begin
                cfg.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && pix_in.valid && pix_in.ready;
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (cfg.valid && cfg.ready) begin
                if (cfg.reg_index == REG_SRC) src_space = cfg.wdata;
                else tgt_space = cfg.wdata;
                cfg_pending = 1'b0;
                quiet_cycles = 0;
            end
            if (pix_in.valid && pix_in.ready) begin
                expected_pixels.insert(expected_pixels.size(),
                                       convert_pixel({pix_in.chan_a_in, pix_in.chan_b_in,
                                                      pix_in.chan_c_in}, src_space, tgt_space));
                quiet_cycles = 0;
            end
            if (pix_out.valid && pix_out.ready) begin
                quiet_cycles = 0;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected word %h %h %h", pix_out.chan_a_out,
                           pix_out.chan_b_out, pix_out.chan_c_out);
                    fail_count++;
                end else begin
                    if (pix_out.chan_a_out !== expected_pixels[0].a) begin
                        $error("chan_a_out expected %0d actual %0d", expected_pixels[0].a,
                               pix_out.chan_a_out);
                        fail_count++;
                    end
                    if (pix_out.chan_b_out !== expected_pixels[0].b) begin
                        $error("chan_b_out expected %0d actual %0d", expected_pixels[0].b,
                               pix_out.chan_b_out);
                        fail_count++;
                    end
                    if (pix_out.chan_c_out !== expected_pixels[0].c) begin
                        $error("chan_c_out expected %0d actual %0d", expected_pixels[0].c,
                               pix_out.chan_c_out);
                        fail_count++;
                    end
                    void'(expected_pixels.pop_front());
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [2:0] value);
        @(negedge i_clk);
        cfg_index = idx;
        cfg_value = value;
        cfg_pending = 1'b1;
        wait (!cfg_pending);
    endtask

    task automatic drain;
        wait (pending_pixels.size() == 0 && !pix_in.valid && expected_pixels.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic queue_pixel(input int a, input int b, input int c);
        pending_pixels.insert(pending_pixels.size(), {a[7:0], b[7:0], c[7:0]});
    endtask

    task automatic run_phase(input logic [2:0] sp, input logic [2:0] tp, input int count);
        t_word w;
        drain();
        write_reg(REG_SRC, sp);
        write_reg(REG_TGT, tp);
        for (int i = 0; i < count; i++) begin
            w = 24'($urandom);
            case ($urandom_range(7))
                0: w.b = w.a;
                1: begin w.b = w.a; w.c = w.a; end
                2: w.a = ($urandom_range(1)) ? 8'd255 : 8'd0;
                3: w.b = 8'd0;
                default: ;
            endcase
            pending_pixels.insert(pending_pixels.size(), w);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(170, 85, 51);
        drain();
        write_reg(REG_SRC, SP_HSV);
        write_reg(REG_TGT, SP_HSL);
        queue_pixel(255, 200, 100);
        queue_pixel(0, 255, 255);
        queue_pixel(128, 0, 77);
        drain();
        write_reg(REG_SRC, SP_HSL);
        write_reg(REG_TGT, SP_HSV);
        queue_pixel(255, 128, 200);
        queue_pixel(40, 0, 90);
        queue_pixel(200, 255, 250);
        drain();
        write_reg(REG_SRC, SP_RGB);
        write_reg(REG_TGT, SP_HSV);
        queue_pixel(50, 50, 50);
        queue_pixel(255, 0, 128);
        queue_pixel(0, 255, 0);
        queue_pixel(10, 20, 255);
        drain();
        write_reg(REG_SRC, SP_601);
        write_reg(REG_TGT, SP_709);
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(255, 0, 255);
        drain();
        write_reg(REG_SRC, 3'd7);
        write_reg(REG_TGT, SP_YCOCG);
        queue_pixel(255, 0, 255);
        queue_pixel(0, 255, 0);
        drain();
        write_reg(REG_SRC, SP_CMY);
        write_reg(REG_TGT, 3'd7);
        queue_pixel(0, 255, 1);
        for (int s = 0; s < 8; s++) begin
            for (int t = 0; t < 8; t++) begin
                idle_pct = (s == 3) ? 0 : 17;
                run_phase(s[2:0], t[2:0], 22);
            end
        end
        idle_pct = 17;
        drain();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
